FILE: sv/global_motion_vector_median_assert.svh
// Assertion macros for the global motion vector median block.
// Included by the back end, which checks its own control logic; needs clk_i and rst_ni in scope.
`ifndef GLOBAL_MOTION_VECTOR_MEDIAN_ASSERT_SVH
`define GLOBAL_MOTION_VECTOR_MEDIAN_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define GMV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define GMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gmv_pkg.sv
// Shared types and constants of the global motion vector median block.
// No dependencies.
package gmv_pkg;

  // Width of the region index field on the input channel
  localparam int GMV_RGN_W = 4;

  // Entries of the queue between front and back
  localparam int GMV_QUEUE_DEPTH = 2;

  // Classification the front attaches to each transaction
  typedef struct packed {
    logic in_range;
    logic frame_done;
  } gmv_cls_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_RUN,
    S_LOAD,
    S_SCAN,
    S_WR_M,
    S_WR_P,
    S_MED_A,
    S_MED_B,
    S_OUT
  } gmv_state_e;

endpackage

FILE: sv/gmv_in_if.sv
// Input channel: one match score per transaction.
// Depends on gmv_pkg for the region field width.
interface gmv_in_if #(
  parameter int XW = 5,
  parameter int YW = 5,
  parameter int SB = 24
);
  import gmv_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [XW-1:0]        offset_x;
  logic [YW-1:0]        offset_y;
  logic [GMV_RGN_W-1:0] region;
  logic [SB-1:0]        score;
  logic                 frame_done;

  modport source (output valid, offset_x, offset_y, region, score, frame_done, input ready);
  modport sink   (input valid, offset_x, offset_y, region, score, frame_done, output ready);
endinterface

FILE: sv/gmv_out_if.sv
// Output channel: one median motion vector per frame.
// No dependencies.
interface gmv_out_if #(
  parameter int XW = 5,
  parameter int YW = 5,
  parameter int SB = 24
);
  logic               valid;
  logic               ready;
  logic signed [SB:0] median_score;
  logic [XW-1:0]      motion_x;
  logic [YW-1:0]      motion_y;

  modport source (output valid, median_score, motion_x, motion_y, input ready);
  modport sink   (input valid, median_score, motion_x, motion_y, output ready);
endinterface

FILE: sv/gmv_front.sv
// Front end: accepts score transactions, classifies them and registers them for the queue.
// Depends on gmv_pkg and gmv_in_if.
module gmv_front #(
  parameter int REGIONS = 16,
  parameter int XW      = 5,
  parameter int YW      = 5,
  parameter int SB      = 24,
  parameter int DW      = 2 + gmv_pkg::GMV_RGN_W + SB + XW + YW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gmv_in_if.sink        in_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output logic [DW-1:0] q_data_o
);
  import gmv_pkg::*;

  logic                 f_vld_q;
  gmv_cls_t             cls_d, cls_q;
  logic [GMV_RGN_W-1:0] rgn_q;
  logic [SB-1:0]        score_q;
  logic [XW-1:0]        x_q;
  logic [YW-1:0]        y_q;
  logic                 take;

  // Accept when the stage is empty or drains this cycle
  assign in_i.ready = !f_vld_q || q_ready_i;
  assign take       = in_i.valid && in_i.ready;

  // Classify: a region beyond the table updates nothing
  always_comb begin
    cls_d.in_range   = {{(32 - GMV_RGN_W){1'b0}}, in_i.region} < 32'(REGIONS);
    cls_d.frame_done = in_i.frame_done;
  end

  // Hold the valid flag of the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (take) begin
      f_vld_q <= 1'b1;
    end else if (q_ready_i) begin
      f_vld_q <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q   <= cls_d;
      rgn_q   <= in_i.region;
      score_q <= in_i.score;
      x_q     <= in_i.offset_x;
      y_q     <= in_i.offset_y;
    end
  end

  assign q_valid_o = f_vld_q;
  assign q_data_o  = {cls_q, rgn_q, score_q, x_q, y_q};
endmodule

FILE: sv/gmv_queue.sv
// Small FIFO that decouples the front end from the back end.
// No dependencies.
module gmv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q < CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = buf_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end
endmodule

FILE: sv/gmv_back.sv
// Back end: best-score table, selection sort sequencer and median output register.
// Depends on gmv_pkg, gmv_out_if and the assertion macro header.
`include "global_motion_vector_median_assert.svh"

module gmv_back #(
  parameter int REGIONS = 16,
  parameter int XW      = 5,
  parameter int YW      = 5,
  parameter int SB      = 24,
  parameter int DW      = 2 + gmv_pkg::GMV_RGN_W + SB + XW + YW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  logic [DW-1:0] q_data_i,
  gmv_out_if.source     out_o
);
  import gmv_pkg::*;

  localparam int AW = $clog2(REGIONS);
  localparam int CW = AW + 1;
  localparam int SW = SB + 1;
  localparam int EW = SW + XW + YW;
  localparam int LO = (REGIONS - 1) / 2;
  localparam int ODD = REGIONS % 2;
  localparam logic [EW-1:0] EMPTY = {{SW{1'b1}}, {(XW + YW){1'b0}}};

  // Unpack the queue head
  gmv_cls_t             h_cls;
  logic [GMV_RGN_W-1:0] h_rgn;
  logic [SB-1:0]        h_score;
  logic [XW-1:0]        h_x;
  logic [YW-1:0]        h_y;

  assign h_y     = q_data_i[YW-1:0];
  assign h_x     = q_data_i[YW +: XW];
  assign h_score = q_data_i[YW + XW +: SB];
  assign h_rgn   = q_data_i[YW + XW + SB +: GMV_RGN_W];
  assign h_cls   = gmv_cls_t'(q_data_i[DW-1 -: $bits(gmv_cls_t)]);

  gmv_state_e state_q, state_d;

  // Table memory with valid bits; an entry that is not valid reads as empty
  logic [EW-1:0]      mem_q [REGIONS];
  logic [REGIONS-1:0] valid_q;
  logic [EW-1:0]      rd_data_q;
  logic               rd_ent_vld_q;
  logic               re, we, clr;
  logic [AW-1:0]      raddr, waddr;
  logic [EW-1:0]      wdata;

  // Read tag and sort registers
  logic [CW-1:0] tag_q, tag_d;
  logic [CW-1:0] i_q, i_d;
  logic [AW-1:0] p_q, p_d;
  logic [AW-1:0] m_q, m_d;
  logic [EW-1:0] ep_q, ep_d, min_q, min_d, a_q, a_d;

  // Update stage registers
  logic          b_vld_q, b_fd_q, b_rng_q;
  logic [AW-1:0] b_addr_q;
  logic [SB-1:0] b_s_q;
  logic [XW-1:0] b_x_q;
  logic [YW-1:0] b_y_q;
  logic          fwd_en_q;
  logic [AW-1:0] fwd_addr_q;
  logic [EW-1:0] fwd_data_q;

  // Output register
  logic               out_vld_q, out_load;
  logic signed [SB:0] o_score_q;
  logic [XW-1:0]      o_x_q;
  logic [YW-1:0]      o_y_q;

  logic               pop;
  logic [EW-1:0]      eff, old_ent, new_ent;
  logic signed [SW-1:0] eff_s, min_s, old_s, new_s, a_s;
  logic [XW-1:0]      eff_x, a_x;
  logic [YW-1:0]      eff_y, a_y;
  logic               upd;
  logic signed [SW:0] sum_s, sum_adj;
  logic [XW:0]        sum_x;
  logic [YW:0]        sum_y;

  // Resolve the registered read into an effective entry
  assign eff   = rd_ent_vld_q ? rd_data_q : EMPTY;
  assign eff_s = $signed(eff[EW-1 -: SW]);
  assign eff_x = eff[YW +: XW];
  assign eff_y = eff[YW-1:0];
  assign min_s = $signed(min_q[EW-1 -: SW]);
  assign a_s   = $signed(a_q[EW-1 -: SW]);
  assign a_x   = a_q[YW +: XW];
  assign a_y   = a_q[YW-1:0];

  // Update path: forward the write of the previous transaction to the same entry
  assign old_ent = (fwd_en_q && fwd_addr_q == b_addr_q) ? fwd_data_q : eff;
  assign old_s   = $signed(old_ent[EW-1 -: SW]);
  assign new_s   = $signed({1'b0, b_s_q});
  assign new_ent = {1'b0, b_s_q, b_x_q, b_y_q};
  assign upd     = b_vld_q && b_rng_q && (old_s == {SW{1'b1}} || old_s > new_s);

  // Median of the two middle entries, halved toward zero
  assign sum_s   = {a_s[SW-1], a_s} + {eff_s[SW-1], eff_s};
  assign sum_adj = sum_s + {{SW{1'b0}}, sum_s[SW]};
  assign sum_x   = {1'b0, a_x} + {1'b0, eff_x};
  assign sum_y   = {1'b0, a_y} + {1'b0, eff_y};

  // Sequencer: next state, memory port control
  always_comb begin
    state_d   = state_q;
    re        = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    q_ready_o = 1'b0;
    out_load  = 1'b0;
    clr       = 1'b0;
    tag_d     = tag_q;
    i_d       = i_q;
    p_d       = p_q;
    m_d       = m_q;
    ep_d      = ep_q;
    min_d     = min_q;
    a_d       = a_q;
    unique case (state_q)
      S_RUN: begin
        we    = upd;
        waddr = b_addr_q;
        wdata = new_ent;
        if (b_vld_q && b_fd_q) begin
          p_d     = '0;
          state_d = S_LOAD;
        end else begin
          q_ready_o = 1'b1;
          re        = q_valid_i;
          raddr     = AW'(h_rgn);
        end
      end
      S_LOAD: begin
        re      = 1'b1;
        raddr   = p_q;
        tag_d   = {1'b0, p_q};
        i_d     = {1'b0, p_q} + CW'(1);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (i_q < CW'(REGIONS)) begin
          re    = 1'b1;
          raddr = i_q[AW-1:0];
          tag_d = i_q;
          i_d   = i_q + CW'(1);
        end
        // Keep the leftmost minimum
        if (tag_q == {1'b0, p_q}) begin
          ep_d  = eff;
          min_d = eff;
          m_d   = p_q;
        end else if (eff_s < min_s) begin
          min_d = eff;
          m_d   = tag_q[AW-1:0];
        end
        if (tag_q == CW'(REGIONS - 1)) begin
          state_d = S_WR_M;
        end
      end
      S_WR_M: begin
        we      = 1'b1;
        waddr   = m_q;
        wdata   = ep_q;
        state_d = S_WR_P;
      end
      S_WR_P: begin
        we    = 1'b1;
        waddr = p_q;
        wdata = min_q;
        if (p_q == AW'(REGIONS - 2)) begin
          state_d = S_MED_A;
        end else begin
          p_d     = p_q + AW'(1);
          state_d = S_LOAD;
        end
      end
      S_MED_A: begin
        re      = 1'b1;
        raddr   = AW'(LO);
        state_d = S_MED_B;
      end
      S_MED_B: begin
        a_d = eff;
        if (ODD == 0) begin
          re    = 1'b1;
          raddr = AW'(LO + 1);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          clr      = 1'b1;
          state_d  = S_RUN;
        end
      end
    endcase
  end

  assign pop = q_valid_i && q_ready_o;

  // Hold state, counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RUN;
      tag_q     <= '0;
      i_q       <= '0;
      p_q       <= '0;
      m_q       <= '0;
      valid_q   <= '0;
      b_vld_q   <= 1'b0;
      fwd_en_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tag_q    <= tag_d;
      i_q      <= i_d;
      p_q      <= p_d;
      m_q      <= m_d;
      b_vld_q  <= pop;
      fwd_en_q <= upd;
      if (clr) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q    <= mem_q[raddr];
      rd_ent_vld_q <= valid_q[raddr];
    end
  end

  // Payload registers of the update stage, sorter and output
  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_fd_q   <= h_cls.frame_done;
      b_rng_q  <= h_cls.in_range;
      b_addr_q <= AW'(h_rgn);
      b_s_q    <= h_score;
      b_x_q    <= h_x;
      b_y_q    <= h_y;
    end
    fwd_addr_q <= b_addr_q;
    fwd_data_q <= new_ent;
    ep_q       <= ep_d;
    min_q      <= min_d;
    a_q        <= a_d;
    if (out_load) begin
      o_score_q <= sum_adj[SW:1];
      o_x_q     <= sum_x[XW:1];
      o_y_q     <= sum_y[YW:1];
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.median_score = o_score_q;
  assign out_o.motion_x     = o_x_q;
  assign out_o.motion_y     = o_y_q;

  `GMV_ASSERT_NEXT(a_fd_starts_sort, state_q == S_RUN && b_vld_q && b_fd_q, state_q == S_LOAD, "frame end did not start the sort")
  `GMV_ASSERT_NEXT(a_out_clears, state_q == S_OUT && (!out_vld_q || out_o.ready), valid_q == '0, "table not cleared after median")
  `GMV_ASSERT_NOW(a_swap_order, state_q == S_WR_M, m_q >= p_q, "minimum index left of sort position")
  `GMV_ASSERT_NOW(a_out_source, $rose(out_vld_q), $past(state_q) == S_OUT, "result loaded outside output state")
endmodule

FILE: sv/global_motion_vector_median.sv
// Top level of the global motion vector median block: front, queue and back end.
// Depends on gmv_pkg, gmv_in_if, gmv_out_if, gmv_front, gmv_queue and gmv_back.
//
//   channel  direction  fields
//   in_i     sink       offset_x, offset_y, region, score, frame_done
//   out_o    source     median_score, motion_x, motion_y
//
// Score transactions are taken one per cycle outside a frame-end sort; each updates one table entry
// through a read-modify-write pipeline with write forwarding.
// A frame end adds a selection sort on the single table read port before the median is loaded.
// Input stalls during the sort once the two-entry queue and the front stage are full.
// Reset empties the table at once through per-entry valid bits; no clearing pass.
module global_motion_vector_median #(
  parameter int REGIONS        = 16,
  parameter int OFFSET_RANGE_X = 32,
  parameter int OFFSET_RANGE_Y = 32,
  parameter int SCORE_BITS     = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gmv_in_if.sink    in_i,
  gmv_out_if.source out_o
);
  import gmv_pkg::*;

  localparam int XW = $clog2(OFFSET_RANGE_X);
  localparam int YW = $clog2(OFFSET_RANGE_Y);
  localparam int DW = $bits(gmv_cls_t) + GMV_RGN_W + SCORE_BITS + XW + YW;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [DW-1:0] f_data, b_data;

  gmv_front #(
    .REGIONS (REGIONS),
    .XW      (XW),
    .YW      (YW),
    .SB      (SCORE_BITS),
    .DW      (DW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (f_valid),
    .q_ready_i (f_ready),
    .q_data_o  (f_data)
  );

  gmv_queue #(
    .WIDTH (DW),
    .DEPTH (GMV_QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  gmv_back #(
    .REGIONS (REGIONS),
    .XW      (XW),
    .YW      (YW),
    .SB      (SCORE_BITS),
    .DW      (DW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (b_valid),
    .q_ready_o (b_ready),
    .q_data_i  (b_data),
    .out_o     (out_o)
  );
endmodule
